@@ design/bpi_pkg.sv @@
`default_nettype none

package bpi_pkg;

    localparam int MV_BITS_DEF  = 16;
    localparam int NUM_POINTS   = 8;
    localparam int SEG_BITS     = 3;
    localparam int PCT_BITS     = 7;
    localparam int CFG_IDX_BITS = 4;
    localparam int OUT_BITS     = 8;

    localparam int unsigned RESET_MV [NUM_POINTS] =
        '{4200, 4100, 3900, 3750, 3700, 3550, 3450, 3000};
    localparam int unsigned RESET_PCT [NUM_POINTS] =
        '{100, 90, 75, 50, 25, 10, 5, 0};

endpackage

`default_nettype wire

@@ design/bpi_div_step.sv @@
`default_nettype none

module bpi_div_step
    import bpi_pkg::*;
#(
    parameter int MV_BITS = MV_BITS_DEF,
    parameter int SHIFT   = 0
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [MV_BITS+PCT_BITS-1:0] in_rem,
    input  wire logic [MV_BITS-1:0]          in_den,
    input  wire logic [PCT_BITS-1:0]         in_q,
    input  wire logic                        in_neg,
    input  wire logic [PCT_BITS-1:0]         in_pct,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [MV_BITS+PCT_BITS-1:0]      out_rem,
    output logic [MV_BITS-1:0]               out_den,
    output logic [PCT_BITS-1:0]              out_q,
    output logic                             out_neg,
    output logic [PCT_BITS-1:0]              out_pct
);

    localparam int RW = MV_BITS + PCT_BITS;

    logic          valid_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [MV_BITS-1:0]  den_reg;
    logic [PCT_BITS-1:0] q_reg, q_next;
    logic          neg_reg;
    logic [PCT_BITS-1:0] pct_reg;
    logic [RW-1:0] den_sh;

    assign in_ready = !valid_reg || out_ready;

    // one restoring step: quotient bit SHIFT
    always_comb
    begin
        den_sh   = RW'(in_den) << SHIFT;
        rem_next = in_rem;
        q_next   = in_q;
        if (in_rem >= den_sh)
        begin
            rem_next     = in_rem - den_sh;
            q_next[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            q_reg   <= q_next;
            neg_reg <= in_neg;
            pct_reg <= in_pct;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_neg   = neg_reg;
    assign out_pct   = pct_reg;

endmodule

`default_nettype wire

@@ design/battery_percent_interpolator_core.sv @@
`default_nettype none

// Maps a battery voltage (s_tdata, millivolts) to a charge percentage
// (m_tdata) by linear interpolation between eight breakpoints held in
// registers written through the cfg port (index 0..7; millivolts in the
// low MV_BITS bits, percent in the 7 bits above; other indexes ignored).
// One item is accepted per cycle unless m_tready holds the pipeline back;
// its stages are segment search, operand select, multiply, seven restoring
// divider stages (one quotient bit each) and the final add. Breakpoints
// must only be written while no item is in flight.
module battery_percent_interpolator_core
    import bpi_pkg::*;
#(
    parameter int MV_BITS = MV_BITS_DEF,
    localparam int IN_W = ((MV_BITS + 7) / 8) * 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [IN_W-1:0]             s_tdata,   // millivolts
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [OUT_BITS-1:0]              m_tdata,   // percent
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [MV_BITS+PCT_BITS-1:0] cfg_data
);

    localparam int RW = MV_BITS + PCT_BITS;

    // breakpoint registers
    logic [MV_BITS-1:0]  bp_mv_reg  [NUM_POINTS];
    logic [PCT_BITS-1:0] bp_pct_reg [NUM_POINTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                bp_mv_reg[i]  <= MV_BITS'(RESET_MV[i]);
                bp_pct_reg[i] <= PCT_BITS'(RESET_PCT[i]);
            end
        end
        else if (cfg_valid && cfg_index < CFG_IDX_BITS'(NUM_POINTS))
        begin
            bp_mv_reg[cfg_index[SEG_BITS-1:0]]  <= cfg_data[MV_BITS-1:0];
            bp_pct_reg[cfg_index[SEG_BITS-1:0]] <= cfg_data[RW-1:MV_BITS];
        end
    end

    // stage A: segment search
    logic                a_valid_reg, a_ready;
    logic [MV_BITS-1:0]  a_mv_reg;
    logic [SEG_BITS-1:0] a_seg_reg, a_seg_next;
    logic                a_fixed_reg, a_fixed_next;
    logic [PCT_BITS-1:0] a_fpct_reg, a_fpct_next;
    logic [MV_BITS-1:0]  mv_in;
    logic                found;

    assign mv_in = s_tdata[MV_BITS-1:0];

    always_comb
    begin
        found      = 1'b0;
        a_seg_next = '0;
        for (int i = NUM_POINTS - 2; i >= 0; i--)
        begin
            if (mv_in <= bp_mv_reg[i] && mv_in > bp_mv_reg[i+1])
            begin
                found      = 1'b1;
                a_seg_next = SEG_BITS'(i);
            end
        end
        a_fixed_next = 1'b1;
        a_fpct_next  = '0;
        if (mv_in >= bp_mv_reg[0])
        begin
            a_fpct_next = bp_pct_reg[0];
        end
        else if (mv_in <= bp_mv_reg[NUM_POINTS-1])
        begin
            a_fpct_next = bp_pct_reg[NUM_POINTS-1];
        end
        else if (found)
        begin
            a_fixed_next = 1'b0;
        end
    end

    // stage B: operand select
    logic                b_valid_reg, b_ready;
    logic [MV_BITS-1:0]  b_num_reg, b_num_next;
    logic [MV_BITS-1:0]  b_den_reg, b_den_next;
    logic [PCT_BITS-1:0] b_mag_reg, b_mag_next;
    logic                b_neg_reg, b_neg_next;
    logic [PCT_BITS-1:0] b_pct_reg, b_pct_next;
    logic [PCT_BITS:0]   dpct;
    logic [SEG_BITS-1:0] seg_lo;

    assign s_tready = a_ready;
    assign a_ready  = !a_valid_reg || b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            a_mv_reg    <= mv_in;
            a_seg_reg   <= a_seg_next;
            a_fixed_reg <= a_fixed_next;
            a_fpct_reg  <= a_fpct_next;
        end
    end

    always_comb
    begin
        seg_lo     = a_seg_reg + SEG_BITS'(1);
        dpct       = {1'b0, bp_pct_reg[a_seg_reg]} - {1'b0, bp_pct_reg[seg_lo]};
        b_neg_next = dpct[PCT_BITS];
        b_mag_next = b_neg_next ? PCT_BITS'(-dpct) : dpct[PCT_BITS-1:0];
        b_num_next = a_mv_reg - bp_mv_reg[seg_lo];
        b_den_next = bp_mv_reg[a_seg_reg] - bp_mv_reg[seg_lo];
        b_pct_next = bp_pct_reg[seg_lo];
        if (a_fixed_reg)
        begin
            // zero numerator, unit divisor: result is the fixed percent
            b_neg_next = 1'b0;
            b_mag_next = '0;
            b_num_next = '0;
            b_den_next = MV_BITS'(1);
            b_pct_next = a_fpct_reg;
        end
    end

    // stage C: multiply
    logic                c_valid_reg, c_ready;
    logic [RW-1:0]       c_rem_reg;
    logic [MV_BITS-1:0]  c_den_reg;
    logic                c_neg_reg;
    logic [PCT_BITS-1:0] c_pct_reg;

    assign b_ready = !b_valid_reg || c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_num_reg <= b_num_next;
            b_den_reg <= b_den_next;
            b_mag_reg <= b_mag_next;
            b_neg_reg <= b_neg_next;
            b_pct_reg <= b_pct_next;
        end
    end

    // divider chain
    logic                d_valid [PCT_BITS+1];
    logic                d_ready [PCT_BITS+1];
    logic [RW-1:0]       d_rem   [PCT_BITS+1];
    logic [MV_BITS-1:0]  d_den   [PCT_BITS+1];
    logic [PCT_BITS-1:0] d_q     [PCT_BITS+1];
    logic                d_neg   [PCT_BITS+1];
    logic [PCT_BITS-1:0] d_pct   [PCT_BITS+1];

    assign c_ready = !c_valid_reg || d_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_rem_reg <= RW'(b_num_reg) * RW'(b_mag_reg);
            c_den_reg <= b_den_reg;
            c_neg_reg <= b_neg_reg;
            c_pct_reg <= b_pct_reg;
        end
    end

    assign d_valid[0] = c_valid_reg;
    assign d_rem[0]   = c_rem_reg;
    assign d_den[0]   = c_den_reg;
    assign d_q[0]     = '0;
    assign d_neg[0]   = c_neg_reg;
    assign d_pct[0]   = c_pct_reg;

    for (genvar k = 0; k < PCT_BITS; k++)
    begin : g_div
        bpi_div_step #(
            .MV_BITS (MV_BITS),
            .SHIFT   (PCT_BITS - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d_valid[k]),
            .in_ready  (d_ready[k]),
            .in_rem    (d_rem[k]),
            .in_den    (d_den[k]),
            .in_q      (d_q[k]),
            .in_neg    (d_neg[k]),
            .in_pct    (d_pct[k]),
            .out_valid (d_valid[k+1]),
            .out_ready (d_ready[k+1]),
            .out_rem   (d_rem[k+1]),
            .out_den   (d_den[k+1]),
            .out_q     (d_q[k+1]),
            .out_neg   (d_neg[k+1]),
            .out_pct   (d_pct[k+1])
        );
    end

    // stage E: apply quotient, output register
    logic                e_valid_reg;
    logic [PCT_BITS-1:0] e_pct_reg, e_pct_next;

    assign d_ready[PCT_BITS] = !e_valid_reg || m_tready;

    always_comb
    begin
        if (d_neg[PCT_BITS])
        begin
            e_pct_next = d_pct[PCT_BITS] - d_q[PCT_BITS];
        end
        else
        begin
            e_pct_next = d_pct[PCT_BITS] + d_q[PCT_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (d_ready[PCT_BITS])
        begin
            e_valid_reg <= d_valid[PCT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready[PCT_BITS] && d_valid[PCT_BITS])
        begin
            e_pct_reg <= e_pct_next;
        end
    end

    assign m_tvalid = e_valid_reg;
    assign m_tdata  = OUT_BITS'(e_pct_reg);

endmodule

`default_nettype wire
